// ===== rtl/bwtd_pkg.sv =====
// Package for the inverse BWT block decoder: constants, codes and shared types.
// No dependencies.
`default_nettype none
package bwtd_pkg;
  localparam int unsigned BlockDepthDefault = 1048576;
  localparam int unsigned NumSymSlots = 257;
  localparam int unsigned NumSyms = 256;

  typedef enum logic [1:0] {
    ST_DATA   = 2'd0,
    ST_END    = 2'd1,
    ST_BADLEN = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  // Queue entry between front and back parts.
  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } item_t;
endpackage
`default_nettype wire

// ===== rtl/bwtd_ram.sv =====
// Generic simple dual-port RAM with one write and one registered read port.
// No dependencies.
`default_nettype none
module bwtd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/bwtd_fifo.sv =====
// Two-entry queue decoupling the input channel from the decoder core.
// Depends on bwtd_pkg.
`default_nettype none
module bwtd_fifo
  import bwtd_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  wire   out_ready_i,
  output item_t out_item_o
);
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bwtd_core.sv =====
// Decoder core: header parsing, loading, prefix sums, successor build, emission.
// Depends on bwtd_pkg and bwtd_ram.
`default_nettype none
module bwtd_core
  import bwtd_pkg::*;
#(
  parameter int unsigned BlockDepth = BlockDepthDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  item_t       in_item_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [1:0]  out_status_o
);
  localparam int unsigned AW = (BlockDepth > 1) ? $clog2(BlockDepth) : 1;
  localparam int unsigned CW = $clog2(BlockDepth + 1);
  localparam int unsigned RD = (BlockDepth > 1) ? BlockDepth : 2;
  localparam logic [CW-1:0] DepthC = CW'(BlockDepth);
  localparam logic [8:0] LastSlot = 9'(NumSymSlots - 1);

  typedef enum logic [14:0] {
    S_LEN   = 15'b000000000000001,
    S_IDX   = 15'b000000000000010,
    S_CLR   = 15'b000000000000100,
    S_LOAD  = 15'b000000000001000,
    S_LINC  = 15'b000000000010000,
    S_PRD   = 15'b000000000100000,
    S_PWR   = 15'b000000001000000,
    S_BRD   = 15'b000000010000000,
    S_BCR   = 15'b000000100000000,
    S_BWR   = 15'b000001000000000,
    S_EMIT  = 15'b000010000000000,
    S_ERD   = 15'b000100000000000,
    S_END   = 15'b001000000000000,
    S_BADL  = 15'b010000000000000,
    S_BADI  = 15'b100000000000000
  } state_e;

  state_e        st_q, st_d;
  logic [31:0]   hdr_q, hdr_d;
  logic [2:0]    hcnt_q, hcnt_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [8:0]    sidx_q, sidx_d;
  logic [CW-1:0] acc_q, acc_d;
  logic          ov_q, ov_d;
  logic [7:0]    ob_q, ob_d;
  logic          ol_q, ol_d;
  logic [1:0]    os_q, os_d;

  // RAM ports.
  logic          bs_we, sc_we;
  logic [AW-1:0] bs_wa, bs_ra, sc_wa, sc_ra;
  logic [7:0]    bs_wd, bs_rd;
  logic [AW-1:0] sc_wd, sc_rd;

  // Symbol count table ports.
  logic          ct_we;
  logic [8:0]    ct_wa, ct_ra;
  logic [CW-1:0] ct_wd, ct_rd;

  logic [31:0] hnext;
  logic        take, out_free;

  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = out_free && (st_q == S_LEN || st_q == S_IDX || st_q == S_LOAD ||
                      st_q == S_EMIT || st_q == S_END || st_q == S_BADL || st_q == S_BADI);
  assign take  = in_valid_i && in_ready_o;
  assign hnext = {hdr_q[23:0], in_item_i.data};

  bwtd_ram #(.Width(8), .Depth(RD)) u_store (
    .clk_i(clk_i), .we_i(bs_we), .waddr_i(bs_wa), .wdata_i(bs_wd),
    .raddr_i(bs_ra), .rdata_o(bs_rd));
  bwtd_ram #(.Width(AW), .Depth(RD)) u_succ (
    .clk_i(clk_i), .we_i(sc_we), .waddr_i(sc_wa), .wdata_i(sc_wd),
    .raddr_i(sc_ra), .rdata_o(sc_rd));
  bwtd_ram #(.Width(CW), .Depth(NumSymSlots)) u_counts (
    .clk_i(clk_i), .we_i(ct_we), .waddr_i(ct_wa), .wdata_i(ct_wd),
    .raddr_i(ct_ra), .rdata_o(ct_rd));

  // Sequencer.
  always_comb begin
    st_d = st_q; hdr_d = hdr_q; hcnt_d = hcnt_q; len_d = len_q; cnt_d = cnt_q;
    cur_d = cur_q; sidx_d = sidx_q; acc_d = acc_q;
    ov_d = ov_q && !out_ready_i; ob_d = ob_q; ol_d = ol_q; os_d = os_q;
    bs_we = 1'b0; bs_wa = cnt_q[AW-1:0]; bs_wd = in_item_i.data; bs_ra = cur_q;
    sc_we = 1'b0; sc_wa = cur_q; sc_wd = cnt_q[AW-1:0]; sc_ra = cur_q;
    ct_we = 1'b0; ct_wa = sidx_q; ct_wd = '0; ct_ra = sidx_q;
    unique case (st_q)
      S_LEN, S_IDX: begin
        if (take && in_item_i.cmd == CMD_FEED) begin
          if (hcnt_q != 3'd3) begin
            hdr_d = hnext; hcnt_d = hcnt_q + 3'd1;
          end else begin
            hdr_d = '0; hcnt_d = '0;
            if (st_q == S_LEN) begin
              if (hnext == 32'd0) begin
                st_d = S_END; ov_d = 1'b1; ob_d = '0; ol_d = 1'b0; os_d = ST_END;
              end else if (hnext > 32'(BlockDepth)) begin
                st_d = S_BADL; ov_d = 1'b1; ob_d = '0; ol_d = 1'b0; os_d = ST_BADLEN;
              end else begin
                len_d = hnext[CW-1:0]; st_d = S_IDX;
              end
            end else begin
              if (hnext >= {{(32-CW){1'b0}}, len_q}) begin
                st_d = S_BADI; ov_d = 1'b1; ob_d = '0; ol_d = 1'b0; os_d = ST_BADIDX;
              end else begin
                cur_d = hnext[AW-1:0]; st_d = S_CLR; sidx_d = '0;
              end
            end
          end
        end
      end
      S_CLR: begin
        // Symbol table cleared one slot per cycle.
        ct_we = 1'b1; ct_wa = sidx_q; ct_wd = '0;
        sidx_d = sidx_q + 9'd1;
        if (sidx_q == LastSlot) begin
          st_d = S_LOAD; cnt_d = '0;
        end
      end
      S_LOAD: begin
        // Store the byte and fetch the count of its slot.
        if (take && in_item_i.cmd == CMD_FEED) begin
          bs_we = 1'b1;
          ct_ra = {1'b0, in_item_i.data} + 9'd1;
          sidx_d = {1'b0, in_item_i.data} + 9'd1;
          cnt_d = cnt_q + CW'(1);
          st_d = S_LINC;
        end
      end
      S_LINC: begin
        ct_we = 1'b1; ct_wa = sidx_q; ct_wd = ct_rd + CW'(1);
        if (cnt_q >= len_q) begin
          st_d = S_PRD; sidx_d = '0; acc_d = '0;
        end else begin
          st_d = S_LOAD;
        end
      end
      S_PRD: begin
        ct_ra = sidx_q; st_d = S_PWR;
      end
      S_PWR: begin
        // One table entry becomes its inclusive prefix sum.
        ct_we = 1'b1; ct_wa = sidx_q; ct_wd = acc_q + ct_rd;
        acc_d = acc_q + ct_rd;
        sidx_d = sidx_q + 9'd1;
        if (sidx_q == LastSlot) begin
          st_d = S_BRD; cnt_d = '0;
        end else begin
          st_d = S_PRD;
        end
      end
      S_BRD: begin
        bs_ra = cnt_q[AW-1:0]; st_d = S_BCR;
      end
      S_BCR: begin
        bs_ra = cnt_q[AW-1:0]; ct_ra = {1'b0, bs_rd}; st_d = S_BWR;
      end
      S_BWR: begin
        // succ[sum[b[i]]++] = i
        ct_we = 1'b1; ct_wa = {1'b0, bs_rd}; ct_wd = ct_rd + CW'(1);
        sc_wa = ct_rd[AW-1:0];
        sc_we = (ct_rd < DepthC);
        sc_wd = cnt_q[AW-1:0];
        cnt_d = cnt_q + CW'(1);
        if (cnt_q + CW'(1) >= len_q) begin
          st_d = S_EMIT; cnt_d = '0;
        end else begin
          st_d = S_BRD;
        end
      end
      S_EMIT: begin
        if (take && in_item_i.cmd == CMD_PULL) begin
          st_d = S_ERD;
        end
      end
      S_ERD: begin
        cur_d = sc_rd; ov_d = 1'b1; ob_d = bs_rd; os_d = ST_DATA;
        cnt_d = cnt_q + CW'(1);
        ol_d = (cnt_q + CW'(1) >= len_q);
        if (cnt_q + CW'(1) >= len_q) begin
          st_d = S_LEN; cnt_d = '0; hdr_d = '0; hcnt_d = '0;
        end else begin
          st_d = S_EMIT;
        end
      end
      S_END, S_BADL, S_BADI: begin
        if (take && in_item_i.cmd == CMD_PULL) begin
          ov_d = 1'b1; ob_d = '0; ol_d = 1'b0;
          os_d = (st_q == S_END) ? ST_END : (st_q == S_BADL) ? ST_BADLEN : ST_BADIDX;
        end
      end
      default: st_d = S_LEN;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LEN; hdr_q <= '0; hcnt_q <= '0; len_q <= '0; cnt_q <= '0;
      cur_q <= '0; sidx_q <= '0; acc_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; hdr_q <= hdr_d; hcnt_q <= hcnt_d; len_q <= len_d; cnt_q <= cnt_d;
      cur_q <= cur_d; sidx_q <= sidx_d; acc_q <= acc_d; ov_q <= ov_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    ob_q <= ob_d; ol_q <= ol_d; os_q <= os_d;
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = ob_q;
  assign out_last_o   = ol_q;
  assign out_status_o = os_q;
endmodule
`default_nettype wire

// ===== rtl/bwt_inverse_block_decoder.sv =====
// Top level of the inverse BWT block decoder: input queue and decoder core.
// Depends on bwtd_pkg, bwtd_fifo, bwtd_core.
//
// Usage: the slave channel carries commands; tuser is cmd (0 feed, 1 pull),
// tdata is the stream byte. Each block is an 8-byte big-endian header
// (length, primary index) followed by the data bytes, fed one per transaction.
// A valid index starts a pass that clears all 257 symbol table slots; each
// data byte is then stored and its count updated before the next is taken.
// After the last data byte the core forms prefix sums over 257 entries and
// builds the successor table, during which no input is taken. A decoded
// byte passes through the queue, the S_EMIT and S_ERD states and the result
// register to the master channel, and the core takes no new pull until
// it is read; status results appear in the cycle after the core takes a pull.
// tlast marks the last byte of a block. Zero length reports end of stream;
// bad length or index give an error status and halt until reset. Reset
// clears all control state; the symbol table is cleared at each block start.
// A stalled receiver holds the result register and the core stops taking
// transactions, while the two-entry queue still absorbs input.
`default_nettype none
module bwt_inverse_block_decoder
  import bwtd_pkg::*;
#(
  parameter int unsigned BLOCK_DEPTH = BlockDepthDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [7:0]  s_axis_tdata,  // [7:0] stream_byte
  input  wire        s_axis_tuser,  // [0] cmd
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic       m_axis_tlast,  // last_of_block
  output logic [1:0] m_axis_tuser   // [1:0] status
);
  item_t in_item, q_item;
  logic  q_valid, q_ready;

  assign in_item.cmd  = s_axis_tuser;
  assign in_item.data = s_axis_tdata;

  bwtd_fifo u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item));

  bwtd_core #(.BlockDepth(BLOCK_DEPTH)) u_core (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_byte_o(m_axis_tdata), .out_last_o(m_axis_tlast), .out_status_o(m_axis_tuser));

  // Only data results carry a last flag.
  a_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == ST_DATA)
    else $error("last flag on a status result");

  // Error and end results carry a zero byte.
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_DATA |-> m_axis_tdata == 8'd0)
    else $error("nonzero byte on a status result");
endmodule
`default_nettype wire
